@@ rtl/psk_pkg.sv @@
`default_nettype none

package psk_pkg;

    localparam int HALF_W = 64;
    localparam int KEY_W  = 2 * HALF_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SW_RDA,
        ST_SW_RDB,
        ST_SW_WRA,
        ST_SW_WRB,
        ST_OUT_RD,
        ST_OUT_HOLD
    } state_t;

endpackage

`default_nettype wire

@@ rtl/psk_ram.sv @@
`default_nettype none

module psk_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/pancake_sort_keys.sv @@
// Keys load at one request per cycle; a request flagged tlast starts the sort.
// Sorting n keys runs through one 128-bit comparator and one RAM read port:
// each pass scans the prefix for its largest key, then flips that key to the end of the prefix,
// one swap at a time, each swap reading both keys and writing them back (RDA, RDB, WRA, WRB).
// Each result is read, then held until taken before the next is read; s_tready is low until the run ends.
// aresetn (synchronous, active low) empties the set; key storage is not cleared.
`default_nettype none

module pancake_sort_keys #(
    parameter int MAX_KEYS  = 64,
    parameter int KEY_BYTES = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // name_hi[63:0], name_lo[127:64]
    input  wire logic         s_tlast,   // last_in
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [127:0] m_tdata,   // sorted_hi[63:0], sorted_lo[127:64]
    output logic              m_tlast    // last_out
);

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int HI_BYTES = (KEY_BYTES >= 8) ? 8 : KEY_BYTES;
    localparam int LO_BYTES = (KEY_BYTES >= 8) ? KEY_BYTES - 8 : 0;
    localparam logic [psk_pkg::HALF_W-1:0] HI_MASK =
        {psk_pkg::HALF_W{1'b1}} << (64 - 8 * HI_BYTES);
    localparam logic [psk_pkg::HALF_W-1:0] LO_MASK =
        {psk_pkg::HALF_W{1'b1}} << (64 - 8 * LO_BYTES);

    psk_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] out_idx_reg, out_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [psk_pkg::KEY_W-1:0] best_key_reg, best_key_next;
    logic [psk_pkg::KEY_W-1:0] tmp_reg, tmp_next;
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic             second_reg, second_next;
    logic             mlast_reg, mlast_next;

    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [psk_pkg::KEY_W-1:0] wr_data;
    logic [IDX_W-1:0]          rd_addr;
    logic [psk_pkg::KEY_W-1:0] rd_data;

    logic             in_acc;
    logic             has_room;
    logic [CNT_W-1:0] count_inc;
    logic             scan_done;
    logic [IDX_W-1:0] last_idx;
    logic             key_gt;
    logic             swap_more;
    logic             out_last;
    logic [psk_pkg::KEY_W-1:0] masked_key;

    assign in_acc     = s_tvalid && s_tready;
    assign has_room   = count_reg < CNT_W'(MAX_KEYS);
    assign count_inc  = has_room ? count_reg + CNT_W'(1) : count_reg;
    assign scan_done  = (scan_reg == len_reg) && !pend_reg;
    assign last_idx   = IDX_W'(len_reg - CNT_W'(1));
    assign key_gt     = {rd_data[63:0], rd_data[127:64]} >
                        {best_key_reg[63:0], best_key_reg[127:64]};
    assign swap_more  = ({1'b0, lo_reg} + (IDX_W+1)'(1)) < ({1'b0, hi_reg} - (IDX_W+1)'(1));
    assign out_last   = (out_idx_reg + CNT_W'(1)) == count_reg;
    assign masked_key = {s_tdata[127:64] & LO_MASK, s_tdata[63:0] & HI_MASK};

    psk_ram #(
        .WIDTH (psk_pkg::KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psk_pkg::ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    state_next = psk_pkg::ST_SCAN;
                end
            end
            psk_pkg::ST_SCAN: begin
                if (scan_done) begin
                    if (best_idx_reg == last_idx) begin
                        state_next = (len_reg == CNT_W'(1)) ? psk_pkg::ST_OUT_RD
                                                             : psk_pkg::ST_SCAN;
                    end else begin
                        state_next = psk_pkg::ST_SW_RDA;
                    end
                end
            end
            psk_pkg::ST_SW_RDA: state_next = psk_pkg::ST_SW_RDB;
            psk_pkg::ST_SW_RDB: state_next = psk_pkg::ST_SW_WRA;
            psk_pkg::ST_SW_WRA: state_next = psk_pkg::ST_SW_WRB;
            psk_pkg::ST_SW_WRB: begin
                if (swap_more || !second_reg) begin
                    state_next = psk_pkg::ST_SW_RDA;
                end else begin
                    state_next = (len_reg == CNT_W'(1)) ? psk_pkg::ST_OUT_RD
                                                         : psk_pkg::ST_SCAN;
                end
            end
            psk_pkg::ST_OUT_RD: state_next = psk_pkg::ST_OUT_HOLD;
            psk_pkg::ST_OUT_HOLD: begin
                if (m_tready) begin
                    state_next = mlast_reg ? psk_pkg::ST_LOAD : psk_pkg::ST_OUT_RD;
                end
            end
            default: state_next = psk_pkg::ST_LOAD;
        endcase
    end

    // outputs and RAM control
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = lo_reg;
        wr_data  = rd_data;
        rd_addr  = lo_reg;
        unique case (state_reg)
            psk_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                wr_en    = in_acc && has_room;
                wr_addr  = count_reg[IDX_W-1:0];
                wr_data  = masked_key;
            end
            psk_pkg::ST_SCAN:   rd_addr = scan_reg[IDX_W-1:0];
            psk_pkg::ST_SW_RDA: rd_addr = lo_reg;
            psk_pkg::ST_SW_RDB: rd_addr = hi_reg;
            psk_pkg::ST_SW_WRA: begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = rd_data;
            end
            psk_pkg::ST_SW_WRB: begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = tmp_reg;
            end
            psk_pkg::ST_OUT_RD:   rd_addr = out_idx_reg[IDX_W-1:0];
            // keep re-reading the same key so the data holds while stalled
            psk_pkg::ST_OUT_HOLD: begin
                m_tvalid = 1'b1;
                rd_addr  = out_idx_reg[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        count_next    = count_reg;
        len_next      = len_reg;
        scan_next     = scan_reg;
        out_idx_next  = out_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        tmp_next      = tmp_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        second_next   = second_reg;
        mlast_next    = mlast_reg;
        unique case (state_reg)
            psk_pkg::ST_LOAD: begin
                if (in_acc) begin
                    count_next = count_inc;
                    len_next   = count_inc;
                end
                scan_next    = '0;
                out_idx_next = '0;
            end
            psk_pkg::ST_SCAN: begin
                if (scan_reg != len_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                if (pend_reg && (pend_idx_reg == '0 || key_gt)) begin
                    best_key_next = rd_data;
                    best_idx_next = pend_idx_reg;
                end
                if (scan_done) begin
                    lo_next = '0;
                    if (best_idx_reg == last_idx) begin
                        len_next  = len_reg - CNT_W'(1);
                        scan_next = '0;
                    end else if (best_idx_reg != '0) begin
                        hi_next     = best_idx_reg;
                        second_next = 1'b0;
                    end else begin
                        hi_next     = last_idx;
                        second_next = 1'b1;
                    end
                end
            end
            psk_pkg::ST_SW_RDB: tmp_next = rd_data;
            psk_pkg::ST_SW_WRB: begin
                if (swap_more) begin
                    lo_next = lo_reg + IDX_W'(1);
                    hi_next = hi_reg - IDX_W'(1);
                end else if (!second_reg) begin
                    lo_next     = '0;
                    hi_next     = last_idx;
                    second_next = 1'b1;
                end else begin
                    len_next  = len_reg - CNT_W'(1);
                    scan_next = '0;
                end
            end
            psk_pkg::ST_OUT_RD: mlast_next = out_last;
            psk_pkg::ST_OUT_HOLD: begin
                if (m_tready) begin
                    out_idx_next = out_idx_reg + CNT_W'(1);
                    if (mlast_reg) begin
                        count_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psk_pkg::ST_LOAD;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        len_reg      <= len_next;
        scan_reg     <= scan_next;
        out_idx_reg  <= out_idx_next;
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        tmp_reg      <= tmp_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        second_reg   <= second_next;
        mlast_reg    <= mlast_next;
    end

    assign m_tdata = rd_data;
    assign m_tlast = mlast_reg;

endmodule

`default_nettype wire
